### rtl/kdtt_pkg.sv
// Shared types, codes and constants of the keyed deadline timer table.
package kdtt_pkg;

  // Command codes
  typedef enum logic [2:0] {
    OP_SET        = 3'd0,
    OP_ADD        = 3'd1,
    OP_CANCEL     = 3'd2,
    OP_QUERY      = 3'd3,
    OP_EXPIRE     = 3'd4,
    OP_EXPIRE_ALL = 3'd5
  } op_t;

  // Result status codes
  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_PRESENT   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EXPIRED   = 3'd4;
  localparam logic [2:0] ST_NONE      = 3'd5;
  localparam logic [2:0] ST_QUERY     = 3'd6;

  localparam int          MAX_RESULTS     = 64;
  localparam logic [33:0] EXPIRE_ALL_SPAN = 34'd10000000000;

  // One heap slot: ordering is deadline first, then key
  typedef struct packed {
    logic [47:0] dl;
    logic [31:0] key;
  } entry_t;

  function automatic logic before_f(entry_t a, entry_t b);
    return {a.dl, a.key} < {b.dl, b.key};
  endfunction

endpackage

### rtl/kdtt_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module kdtt_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/keyed_deadline_timer_table_unit.sv
// Keyed deadline timer table: a min-heap of (deadline, key) in one RAM plus a
// key lookup. One command is handled at a time; in_ready is high only while
// the unit is idle. A set, add, cancel or query first scans the heap for the
// key, one entry per cycle (up to the fill count). Each heap sift level reads
// the parent going up and the left and right children going down, all through
// the single heap RAM read port. An expire removes one key per root pass,
// collects up to 64 keys in a result buffer, and then hands them out, each
// result taking a buffer read, a load and an output transfer that waits out
// any output stall. Every result carries the earliest deadline and armed flag
// as they stand after the whole command.
module keyed_deadline_timer_table_unit #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [31:0] key,
  input  logic [47:0] deadline,
  input  logic [47:0] now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] out_key,
  output logic        present,
  output logic [47:0] earliest_deadline,
  output logic        armed,
  output logic        last
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;
  localparam int RW = $clog2(kdtt_pkg::MAX_RESULTS);
  localparam int NW = $clog2(kdtt_pkg::MAX_RESULTS + 1);
  localparam int EW = $bits(kdtt_pkg::entry_t);

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_FIND   = 17'h00002,
    S_DISP   = 17'h00004,
    S_REM    = 17'h00008,
    S_UPRD   = 17'h00010,
    S_UPCMP  = 17'h00020,
    S_DNL    = 17'h00040,
    S_DNR    = 17'h00080,
    S_DNR2   = 17'h00100,
    S_DNCMP  = 17'h00200,
    S_EXCHK  = 17'h00400,
    S_EXEVAL = 17'h00800,
    S_RTRD   = 17'h01000,
    S_RTWT   = 17'h02000,
    S_DRRD   = 17'h04000,
    S_DRLD   = 17'h08000,
    S_OUT    = 17'h10000
  } state_t;

  state_t state;

  // Command registers
  logic [2:0]  op;
  logic [31:0] key_r;
  logic [47:0] dl_r;
  logic [48:0] limit;

  // Heap bookkeeping
  logic [CW-1:0]   cnt;
  logic [AW-1:0]   chk;
  logic            found;
  logic [AW-1:0]   pos;
  logic [AW-1:0]   i;
  kdtt_pkg::entry_t elem;
  kdtt_pkg::entry_t cbest;
  logic [AW-1:0]   cidx;
  logic            exp_mode;
  logic [NW-1:0]   nres;
  logic [RW-1:0]   j;
  logic [2:0]      st;
  logic [31:0]     okey;
  logic            pres;

  // RAM ports
  logic             h_we, h_re;
  logic [AW-1:0]    h_waddr, h_raddr;
  kdtt_pkg::entry_t h_wdata, h_rdata;
  logic [EW-1:0]    h_rdata_raw;
  logic             b_we, b_re;
  logic [31:0]      b_rdata;

  logic [XW-1:0] lx, cntx;
  logic [AW-1:0] parent;
  logic          exp_hit;

  assign h_rdata = kdtt_pkg::entry_t'(h_rdata_raw);
  assign lx      = {1'b0, i, 1'b1};
  assign cntx    = XW'(cnt);
  assign parent  = AW'((i - 1'b1) >> 1);
  assign exp_hit = {1'b0, h_rdata.dl} < limit;
  assign in_ready = (state == S_IDLE);

  kdtt_ram #(.Width(EW), .Depth(CAPACITY)) u_heap (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (h_re),
    .raddr (h_raddr),
    .rdata (h_rdata_raw)
  );

  kdtt_ram #(.Width(32), .Depth(kdtt_pkg::MAX_RESULTS)) u_rbuf (
    .clk   (clk),
    .we    (b_we),
    .waddr (nres[RW-1:0]),
    .wdata (h_rdata.key),
    .re    (b_re),
    .raddr (j),
    .rdata (b_rdata)
  );

  // Heap and buffer access per state
  always_comb begin
    h_we    = 1'b0;
    h_re    = 1'b0;
    h_waddr = i;
    h_wdata = elem;
    h_raddr = '0;
    b_we    = 1'b0;
    b_re    = 1'b0;
    unique case (state)
      S_IDLE, S_EXCHK, S_RTRD: h_re = 1'b1;
      S_FIND: begin
        h_re    = 1'b1;
        h_raddr = AW'(chk + 1'b1);
      end
      S_DISP: begin
        h_re    = 1'b1;
        h_raddr = AW'(cnt - 1'b1);
      end
      S_EXEVAL: begin
        h_re    = 1'b1;
        h_raddr = AW'(cnt - 1'b1);
        b_we    = exp_hit;
      end
      S_UPRD: begin
        h_re    = 1'b1;
        h_raddr = parent;
      end
      S_UPCMP: begin
        if (kdtt_pkg::before_f(elem, h_rdata)) begin
          h_we    = 1'b1;
          h_wdata = h_rdata;
        end
      end
      S_DNL: begin
        h_re    = 1'b1;
        h_raddr = AW'(lx);
        h_we    = (lx >= cntx);
      end
      S_DNR: begin
        h_re    = 1'b1;
        h_raddr = AW'(lx + 1'b1);
      end
      S_DNCMP: begin
        h_we    = 1'b1;
        h_wdata = kdtt_pkg::before_f(cbest, elem) ? cbest : elem;
      end
      S_DRRD: b_re = 1'b1;
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op       <= opcode;
            key_r    <= key;
            dl_r     <= deadline;
            limit    <= (opcode == kdtt_pkg::OP_EXPIRE_ALL) ?
                        49'(now) + 49'(kdtt_pkg::EXPIRE_ALL_SPAN) : 49'(now);
            chk      <= '0;
            found    <= 1'b0;
            exp_mode <= 1'b0;
            nres     <= '0;
            pres     <= 1'b0;
            okey     <= '0;
            st       <= kdtt_pkg::ST_DONE;
            state    <= (opcode <= kdtt_pkg::OP_QUERY && cnt != '0) ? S_FIND : S_DISP;
          end
        end
        // Key lookup, one entry per cycle
        S_FIND: begin
          if (h_rdata.key == key_r) begin
            found <= 1'b1;
            pos   <= chk;
            state <= S_DISP;
          end else if (XW'(chk) + 1'b1 >= cntx) begin
            state <= S_DISP;
          end else begin
            chk <= chk + 1'b1;
          end
        end
        S_DISP: begin
          case (op)
            kdtt_pkg::OP_SET, kdtt_pkg::OP_ADD: begin
              elem <= '{dl: dl_r, key: key_r};
              if (found) begin
                if (op == kdtt_pkg::OP_SET) begin
                  i     <= pos;
                  state <= S_UPRD;
                end else begin
                  st    <= kdtt_pkg::ST_PRESENT;
                  state <= S_RTRD;
                end
              end else if (cntx >= XW'(CAPACITY)) begin
                st    <= kdtt_pkg::ST_FULL;
                state <= S_RTRD;
              end else begin
                i     <= AW'(cnt);
                cnt   <= cnt + 1'b1;
                state <= S_UPRD;
              end
            end
            kdtt_pkg::OP_CANCEL: begin
              if (found) begin
                cnt   <= cnt - 1'b1;
                i     <= pos;
                state <= (XW'(pos) < cntx - 1'b1) ? S_REM : S_RTRD;
              end else begin
                st    <= kdtt_pkg::ST_NOT_FOUND;
                state <= S_RTRD;
              end
            end
            kdtt_pkg::OP_QUERY: begin
              st    <= kdtt_pkg::ST_QUERY;
              okey  <= key_r;
              pres  <= found;
              state <= S_RTRD;
            end
            kdtt_pkg::OP_EXPIRE, kdtt_pkg::OP_EXPIRE_ALL: begin
              exp_mode <= 1'b1;
              st       <= kdtt_pkg::ST_NONE;
              state    <= S_EXCHK;
            end
            default: state <= S_RTRD;
          endcase
        end
        // Last entry fills the hole
        S_REM: begin
          elem  <= h_rdata;
          state <= S_UPRD;
        end
        S_UPRD: state <= (i == '0) ? S_DNL : S_UPCMP;
        S_UPCMP: begin
          if (kdtt_pkg::before_f(elem, h_rdata)) begin
            i     <= parent;
            state <= S_UPRD;
          end else begin
            state <= S_DNL;
          end
        end
        S_DNL: begin
          if (lx >= cntx) begin
            state <= exp_mode ? S_EXCHK : S_RTRD;
          end else begin
            state <= S_DNR;
          end
        end
        S_DNR: begin
          cbest <= h_rdata;
          cidx  <= AW'(lx);
          state <= (lx + 1'b1 < cntx) ? S_DNR2 : S_DNCMP;
        end
        S_DNR2: begin
          if (kdtt_pkg::before_f(h_rdata, cbest)) begin
            cbest <= h_rdata;
            cidx  <= AW'(lx + 1'b1);
          end
          state <= S_DNCMP;
        end
        S_DNCMP: begin
          if (kdtt_pkg::before_f(cbest, elem)) begin
            i     <= cidx;
            state <= S_DNL;
          end else begin
            state <= exp_mode ? S_EXCHK : S_RTRD;
          end
        end
        // Expire loop: check root
        S_EXCHK: begin
          state <= (nres < NW'(kdtt_pkg::MAX_RESULTS) && cnt != '0) ? S_EXEVAL : S_RTRD;
        end
        S_EXEVAL: begin
          if (exp_hit) begin
            nres  <= nres + 1'b1;
            st    <= kdtt_pkg::ST_EXPIRED;
            cnt   <= cnt - 1'b1;
            i     <= '0;
            state <= (cnt > CW'(1)) ? S_REM : S_EXCHK;
          end else begin
            state <= S_RTRD;
          end
        end
        S_RTRD: state <= S_RTWT;
        S_RTWT: begin
          earliest_deadline <= (cnt != '0) ? h_rdata.dl : '0;
          armed             <= (cnt != '0);
          if (st == kdtt_pkg::ST_EXPIRED) begin
            j     <= '0;
            state <= S_DRRD;
          end else begin
            out_valid <= 1'b1;
            status    <= st;
            out_key   <= okey;
            present   <= pres;
            last      <= 1'b1;
            state     <= S_OUT;
          end
        end
        // Drain the expired keys
        S_DRRD: state <= S_DRLD;
        S_DRLD: begin
          out_valid <= 1'b1;
          status    <= kdtt_pkg::ST_EXPIRED;
          out_key   <= b_rdata;
          present   <= 1'b0;
          last      <= (NW'(j) + 1'b1 == nres);
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= S_IDLE;
            end else begin
              j     <= j + 1'b1;
              state <= S_DRRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/kdtt_checker.sv
// Port-level checks of the timer table and their bind to the top level.
module kdtt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [47:0] earliest_deadline,
  input logic        armed,
  input logic        last
);

  // A result held back keeps showing
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // No new command while a result is pending
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready with result pending");

  // An accepted command blocks the input the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after transfer");

  // Only expired keys come in multi-result groups
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != kdtt_pkg::ST_EXPIRED |-> last)
    else $error("single result not marked last");

  // An empty table reports deadline zero
  a_idle_dl: assert property (@(posedge clk) disable iff (rst)
    out_valid && !armed |-> earliest_deadline == '0)
    else $error("nonzero deadline with timer disarmed");

endmodule

bind keyed_deadline_timer_table_unit kdtt_checker u_kdtt_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .status            (status),
  .earliest_deadline (earliest_deadline),
  .armed             (armed),
  .last              (last)
);

### tb/sv/tb_keyed_deadline_timer_table_unit.sv
// Self-checking testbench of the keyed deadline timer table unit.
`timescale 1ns / 100ps

// Expected-result store with its own heap model of the timer table
class timer_scoreboard;
  localparam int CAP = 64;

  logic [47:0] dl_q[CAP];
  logic [31:0] key_q[CAP];
  int          fill;
  logic [85:0] pending[$]; // {status, key, present, earliest, armed, last}
  logic [2:0]  new_st[$];
  logic [31:0] new_key[$];
  logic        new_pres[$];
  int          errors;
  int          n_results;
  int          n_expired;

  function new();
    fill = 0;
    errors = 0;
    n_results = 0;
    n_expired = 0;
  endfunction

  function bit lower(int a, int b);
    return {dl_q[a], key_q[a]} < {dl_q[b], key_q[b]};
  endfunction

  function void swap(int a, int b);
    logic [47:0] d;
    logic [31:0] k;
    d = dl_q[a];
    k = key_q[a];
    dl_q[a] = dl_q[b];
    key_q[a] = key_q[b];
    dl_q[b] = d;
    key_q[b] = k;
  endfunction

  function int bubble_up(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!lower(i, p)) break;
      swap(i, p);
      i = p;
    end
    return i;
  endfunction

  function void bubble_down(int i);
    int l;
    int m;
    forever begin
      l = 2 * i + 1;
      if (l >= fill) break;
      m = l;
      if (l + 1 < fill && lower(l + 1, l)) m = l + 1;
      if (!lower(m, i)) break;
      swap(m, i);
      i = m;
    end
  endfunction

  function void drop_slot(int i);
    fill--;
    if (i < fill) begin
      dl_q[i] = dl_q[fill];
      key_q[i] = key_q[fill];
      bubble_down(bubble_up(i));
    end
  endfunction

  function int locate(logic [31:0] k);
    for (int i = 0; i < fill; i++)
      if (key_q[i] == k) return i;
    return fill;
  endfunction

  function bit is_full();
    return fill >= CAP;
  endfunction

  // Stage one result of the current command
  function void stage_result(logic [2:0] s, logic [31:0] k, logic p);
    new_st = {new_st, s};
    new_key = {new_key, k};
    new_pres = {new_pres, p};
  endfunction

  // Apply one accepted command and queue its results
  function void note_command(logic [2:0] op, logic [31:0] k, logic [47:0] d,
                             logic [47:0] t);
    logic [48:0] lim;
    int          pos;
    logic [47:0] ed;
    logic [85:0] ent;
    new_st.delete();
    new_key.delete();
    new_pres.delete();
    pos = locate(k);
    case (op)
      kdtt_pkg::OP_SET, kdtt_pkg::OP_ADD: begin
        if (pos < fill) begin
          if (op == kdtt_pkg::OP_SET) begin
            dl_q[pos] = d;
            bubble_down(bubble_up(pos));
            stage_result(kdtt_pkg::ST_DONE, '0, 1'b0);
          end else begin
            stage_result(kdtt_pkg::ST_PRESENT, '0, 1'b0);
          end
        end else if (fill >= CAP) begin
          stage_result(kdtt_pkg::ST_FULL, '0, 1'b0);
        end else begin
          dl_q[fill] = d;
          key_q[fill] = k;
          fill++;
          void'(bubble_up(fill - 1));
          stage_result(kdtt_pkg::ST_DONE, '0, 1'b0);
        end
      end
      kdtt_pkg::OP_CANCEL: begin
        if (pos < fill) begin
          drop_slot(pos);
          stage_result(kdtt_pkg::ST_DONE, '0, 1'b0);
        end else begin
          stage_result(kdtt_pkg::ST_NOT_FOUND, '0, 1'b0);
        end
      end
      kdtt_pkg::OP_QUERY: begin
        stage_result(kdtt_pkg::ST_QUERY, k, pos < fill);
      end
      kdtt_pkg::OP_EXPIRE, kdtt_pkg::OP_EXPIRE_ALL: begin
        lim = (op == kdtt_pkg::OP_EXPIRE_ALL) ?
              {1'b0, t} + 49'(kdtt_pkg::EXPIRE_ALL_SPAN) : {1'b0, t};
        while (new_st.size() < kdtt_pkg::MAX_RESULTS && fill > 0 &&
               {1'b0, dl_q[0]} < lim) begin
          stage_result(kdtt_pkg::ST_EXPIRED, key_q[0], 1'b0);
          drop_slot(0);
          n_expired++;
        end
        if (new_st.size() == 0) begin
          stage_result(kdtt_pkg::ST_NONE, '0, 1'b0);
        end
      end
      default: begin
        stage_result(kdtt_pkg::ST_DONE, '0, 1'b0);
      end
    endcase
    ed = (fill > 0) ? dl_q[0] : '0;
    foreach (new_st[i]) begin
      ent = {new_st[i], new_key[i], new_pres[i], ed, fill > 0, i == new_st.size() - 1};
      pending = {pending, ent};
    end
  endfunction

  // Compare one result transfer with the oldest expectation
  function void check_result(logic [2:0] st, logic [31:0] k, logic p,
                             logic [47:0] ed, logic a, logic l);
    logic [85:0] e;
    n_results++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result status=%0d key=%h", $time, st, k);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e[85:83] != st) begin
      $display("%0t: status expected %0d actual %0d", $time, e[85:83], st);
      errors++;
    end
    if (e[82:51] != k) begin
      $display("%0t: out_key expected %h actual %h", $time, e[82:51], k);
      errors++;
    end
    if (e[50] != p) begin
      $display("%0t: present expected %b actual %b", $time, e[50], p);
      errors++;
    end
    if (e[49:2] != ed) begin
      $display("%0t: earliest_deadline expected %h actual %h", $time, e[49:2], ed);
      errors++;
    end
    if (e[1] != a) begin
      $display("%0t: armed expected %b actual %b", $time, e[1], a);
      errors++;
    end
    if (e[0] != l) begin
      $display("%0t: last expected %b actual %b", $time, e[0], l);
      errors++;
    end
  endfunction
endclass

module tb_keyed_deadline_timer_table_unit;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  opcode = '0;
  logic [31:0] key = '0;
  logic [47:0] deadline = '0;
  logic [47:0] now = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [31:0] out_key;
  logic        present;
  logic [47:0] earliest_deadline;
  logic        armed;
  logic        last;

  timer_scoreboard sb;
  logic [31:0] key_pool[16];
  bit          hold_off = 1'b0;
  int          idle_cycles = 0;

  keyed_deadline_timer_table_unit dut (.*);

  always #5 clk = ~clk;

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // Offer one command and hold it until the transfer; valid stays up after it
  task automatic send_command(logic [2:0] op, logic [31:0] k, logic [47:0] d,
                              logic [47:0] t);
    in_valid <= 1'b1;
    opcode <= op;
    key <= k;
    deadline <= d;
    now <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_command(op, k, d, t);
  endtask

  // Drop valid only when a real gap follows
  task automatic idle_gap();
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Random command, mostly drawn from a small key pool so that hits occur
  task automatic random_command();
    logic [2:0]  op;
    logic [31:0] k;
    logic [47:0] d;
    logic [47:0] t;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 30) op = kdtt_pkg::OP_SET;
    else if (r < 50) op = kdtt_pkg::OP_ADD;
    else if (r < 65) op = kdtt_pkg::OP_CANCEL;
    else if (r < 80) op = kdtt_pkg::OP_QUERY;
    else if (r < 92) op = kdtt_pkg::OP_EXPIRE;
    else if (r < 97) op = kdtt_pkg::OP_EXPIRE_ALL;
    else op = 3'($urandom_range(6, 7));
    k = ($urandom_range(0, 3) == 0) ? $urandom() : key_pool[$urandom_range(0, 15)];
    d = ($urandom_range(0, 4) == 0) ? 48'({$urandom(), $urandom()}) :
        48'($urandom_range(0, 2000));
    t = ($urandom_range(0, 4) == 0) ? 48'({$urandom(), $urandom()}) :
        48'($urandom_range(0, 2000));
    send_command(op, k, d, t);
  endtask

  // Receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 3) != 0);
    if (!rst && out_valid && out_ready)
      sb.check_result(status, out_key, present, earliest_deadline, armed, last);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off)
      idle_cycles <= 0;
    else if (in_valid || sb.pending.size() > 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    sb = new();
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: edges of every field and each special case
    send_command(kdtt_pkg::OP_EXPIRE, 32'd5, '0, '0);
    send_command(kdtt_pkg::OP_CANCEL, 32'd5, '0, '0);
    send_command(kdtt_pkg::OP_QUERY, '1, '0, '0);
    send_command(kdtt_pkg::OP_SET, '0, '1, '0);
    send_command(kdtt_pkg::OP_ADD, '1, '0, '1);
    send_command(kdtt_pkg::OP_ADD, '1, 48'd7, '0);
    send_command(kdtt_pkg::OP_SET, '1, 48'd100, '0);
    send_command(kdtt_pkg::OP_SET, 32'd3, 48'd100, '0);
    send_command(kdtt_pkg::OP_QUERY, 32'd3, '0, '0);
    send_command(3'd6, 32'd3, '1, '1);
    send_command(3'd7, '1, '1, '1);
    send_command(kdtt_pkg::OP_EXPIRE, '0, '0, 48'd100);
    send_command(kdtt_pkg::OP_EXPIRE, '0, '0, 48'd101);
    send_command(kdtt_pkg::OP_CANCEL, '0, '0, '0);
    send_command(kdtt_pkg::OP_EXPIRE_ALL, '0, '0, '1);
    // Fill to capacity, then overflow with both inserts
    for (int i = 0; i < 64; i++)
      send_command(kdtt_pkg::OP_ADD, 32'(i * 7 + 1), 48'($urandom_range(0, 50)), '0);
    send_command(kdtt_pkg::OP_SET, 32'hdead, 48'd1, '0);
    send_command(kdtt_pkg::OP_ADD, 32'hbeef, 48'd1, '0);
    send_command(kdtt_pkg::OP_SET, 32'd8, 48'd0, '0);
    // Full drain: all 64 keys in one expire-all
    send_command(kdtt_pkg::OP_EXPIRE_ALL, '0, '0, 48'd0);

    // Long receiver hold-off while commands keep coming
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) random_command();
    join

    // Random part, with one mass expire after filling
    for (int i = 0; i < 200; i++) begin
      idle_gap();
      if (i == 100) begin
        for (int j = 0; j < 66; j++) begin
          idle_gap();
          send_command(kdtt_pkg::OP_SET, $urandom(), 48'({$urandom(), $urandom()}), '0);
        end
        send_command(kdtt_pkg::OP_EXPIRE_ALL, '0, '0, '1);
      end else begin
        random_command();
      end
    end
    in_valid <= 1'b0;

    while (sb.pending.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Ran %0d results, %0d expired keys, covering all commands, full table",
             sb.n_results, sb.n_expired);
    $display("and a long output hold-off.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

### files.f
rtl/kdtt_pkg.sv
rtl/kdtt_ram.sv
rtl/keyed_deadline_timer_table_unit.sv
rtl/kdtt_checker.sv
tb/sv/tb_keyed_deadline_timer_table_unit.sv
